[rtl/core/ohs_pkg.sv]
`timescale 1ns / 1ps

package ohs_pkg;

  // Fixed field widths of the item formats.
  localparam int KEY_BITS   = 32;
  localparam int ACTION_W   = 2;
  localparam int STATUS_W   = 3;
  localparam int SLOT_IDX_W = 10;
  localparam int COUNT_W    = 11;

  // Default table size for the top level.
  localparam int SLOT_COUNT_DEF = 1024;

  localparam logic [COUNT_W-1:0] LIMIT_RESET = 11'd512;

  localparam logic [KEY_BITS-1:0] EMPTY_MARK = '0;
  localparam logic [KEY_BITS-1:0] TOMB_MARK  = '1;

  localparam logic [ACTION_W-1:0] ACT_INSERT   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_CONTAINS = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_REMOVE   = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_PRESENT  = 3'd1,
    ST_FOUND    = 3'd2,
    ST_ABSENT   = 3'd3,
    ST_REMOVED  = 3'd4,
    ST_FULL     = 3'd5,
    ST_RESERVED = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_PROBE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [KEY_BITS-1:0] key;
  } in_item_t;

  typedef struct packed {
    status_t               status;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic [COUNT_W-1:0]    live_count;
    logic [COUNT_W-1:0]    probe_count;
  } out_item_t;

endpackage

[rtl/core/ohs_ram.sv]
`timescale 1ns / 1ps

module ohs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/open_addressing_hash_set.sv]
`timescale 1ns / 1ps
// An item whose key is probed goes from idle through S_PROBE, one probed slot per cycle, to
// S_DONE, which loads the output register; a reserved key or an insert over the occupancy
// limit goes from idle straight to S_DONE. A new item is taken only once the sequencer is
// back in idle; a stalled result register holds the sequencer in its hand-off state.
// Reset: synchronous, active low. After reset the block sweeps the slot memory, writing one
// empty slot per cycle, so no item is accepted until the sweep is done.

module open_addressing_hash_set
  import ohs_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,

  input  logic               in_valid,
  output logic               in_stall,
  input  in_item_t           in_item,

  output logic               out_valid,
  input  logic               out_stall,
  output out_item_t          out_item,

  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [COUNT_W-1:0] cfg_data
);

  // Slot index width, and counter width wide enough to hold SLOT_COUNT itself.
  localparam int SLOT_W = $clog2(SLOT_COUNT);
  localparam int CNT_W  = SLOT_W + 1;
  // Width for the occupancy compare, one bit above the wider operand.
  localparam int CMP_W  = ((CNT_W > COUNT_W) ? CNT_W : COUNT_W) + 1;

  // Sequencer state and the item being worked on.
  state_t                state_r, state_nxt;
  logic [SLOT_W-1:0]     pos_r, pos_nxt;
  logic [CNT_W-1:0]      n_r, n_nxt;
  logic                  tomb_seen_r, tomb_seen_nxt;
  logic [SLOT_W-1:0]     tomb_pos_r, tomb_pos_nxt;
  logic [ACTION_W-1:0]   action_r, action_nxt;
  logic [KEY_BITS-1:0]   key_r, key_nxt;

  // Table occupancy: slots used (live keys plus tombstones) and tombstones.
  logic [CNT_W-1:0]      used_r, used_nxt;
  logic [CNT_W-1:0]      tomb_r, tomb_nxt;
  logic [COUNT_W-1:0]    limit_r;

  // Result of the current item, held until the output register is free.
  status_t               res_status_r, res_status_nxt;
  logic [SLOT_W-1:0]     res_slot_r, res_slot_nxt;
  logic [CNT_W-1:0]      res_probes_r, res_probes_nxt;

  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_item_r, out_item_nxt;

  // Slot memory ports.
  logic                  ram_we;
  logic [SLOT_W-1:0]     ram_waddr;
  logic [KEY_BITS-1:0]   ram_wdata;
  logic                  ram_re;
  logic [SLOT_W-1:0]     ram_raddr;
  logic [KEY_BITS-1:0]   ram_rdata;

  ohs_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (SLOT_COUNT)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The occupancy limit register can be written at any time; writes are only
  // expected while no item is in flight.
  assign cfg_ready = 1'b1;

  // Items are taken only while the sequencer waits in idle. A finished result
  // sitting in the output register does not block the next item.
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Insert is refused up front when one more used slot would pass the limit.
  logic [CMP_W-1:0] used_plus1;
  logic [CMP_W-1:0] limit_ext;
  logic             over_limit;

  assign used_plus1 = {{(CMP_W - CNT_W){1'b0}}, used_r} + CMP_W'(1);
  assign limit_ext  = {{(CMP_W - COUNT_W){1'b0}}, limit_r};
  assign over_limit = used_plus1 > limit_ext;

  // Probe evaluation: the memory word read for pos_r is in ram_rdata during
  // S_PROBE. The probe step grows by one each time, so the next slot is
  // pos + (number of probes so far), which gives the triangular sequence.
  logic [CNT_W-1:0] n_inc;
  logic             is_empty;
  logic             is_tomb;
  logic             is_hit;
  logic             at_bound;
  logic             tomb_any;
  logic [SLOT_W-1:0] tomb_sel;
  logic             act_insert;
  logic             act_remove;
  logic             in_reserved;

  assign n_inc      = n_r + CNT_W'(1);
  assign is_empty   = (ram_rdata == EMPTY_MARK);
  assign is_tomb    = (ram_rdata == TOMB_MARK);
  assign is_hit     = !is_empty && !is_tomb && (ram_rdata == key_r);
  assign at_bound   = (n_inc == CNT_W'(SLOT_COUNT));
  assign tomb_any   = tomb_seen_r || is_tomb;
  assign tomb_sel   = tomb_seen_r ? tomb_pos_r : pos_r;
  assign act_insert = (action_r == ACT_INSERT);
  assign act_remove = (action_r == ACT_REMOVE);
  assign in_reserved = (in_item.key == EMPTY_MARK) || (in_item.key == TOMB_MARK);

  // Output field formatting: every field is cut or zero-extended to its width.
  logic [SLOT_W+SLOT_IDX_W-1:0] slot_wide;
  logic [CNT_W+COUNT_W-1:0]     live_wide;
  logic [CNT_W+COUNT_W-1:0]     probes_wide;
  logic [CNT_W-1:0]             live;

  assign live        = used_r - tomb_r;
  assign slot_wide   = {{SLOT_IDX_W{1'b0}}, res_slot_r};
  assign live_wide   = {{COUNT_W{1'b0}}, live};
  assign probes_wide = {{COUNT_W{1'b0}}, res_probes_r};

  always_comb begin
    state_nxt      = state_r;
    pos_nxt        = pos_r;
    n_nxt          = n_r;
    tomb_seen_nxt  = tomb_seen_r;
    tomb_pos_nxt   = tomb_pos_r;
    action_nxt     = action_r;
    key_nxt        = key_r;
    used_nxt       = used_r;
    tomb_nxt       = tomb_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_probes_nxt = res_probes_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_item_nxt   = out_item_r;
    ram_we         = 1'b0;
    ram_waddr      = pos_r;
    ram_wdata      = EMPTY_MARK;
    ram_re         = 1'b0;
    ram_raddr      = pos_r;

    case (state_r)
      S_CLEAR: begin
        // Post-reset sweep: mark every slot empty, one per cycle.
        ram_we    = 1'b1;
        ram_waddr = pos_r;
        ram_wdata = EMPTY_MARK;
        pos_nxt   = pos_r + SLOT_W'(1);
        if (pos_r == {SLOT_W{1'b1}}) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          action_nxt     = in_item.action;
          key_nxt        = in_item.key;
          res_slot_nxt   = '0;
          res_probes_nxt = '0;
          if (in_reserved) begin
            res_status_nxt = ST_RESERVED;
            state_nxt      = S_DONE;
          end else if ((in_item.action == ACT_INSERT) && over_limit) begin
            res_status_nxt = ST_FULL;
            state_nxt      = S_DONE;
          end else begin
            // Start at the home slot: the key's low bits.
            pos_nxt       = in_item.key[SLOT_W-1:0];
            n_nxt         = '0;
            tomb_seen_nxt = 1'b0;
            ram_re        = 1'b1;
            ram_raddr     = in_item.key[SLOT_W-1:0];
            state_nxt     = S_PROBE;
          end
        end
      end

      S_PROBE: begin
        n_nxt = n_inc;
        if (is_tomb && !tomb_seen_r) begin
          tomb_seen_nxt = 1'b1;
          tomb_pos_nxt  = pos_r;
        end
        if (is_hit) begin
          res_probes_nxt = n_inc;
          res_slot_nxt   = pos_r;
          state_nxt      = S_DONE;
          if (act_insert) begin
            res_status_nxt = ST_PRESENT;
          end else if (act_remove) begin
            // Removal leaves a tombstone so later keys on this chain stay reachable.
            ram_we         = 1'b1;
            ram_waddr      = pos_r;
            ram_wdata      = TOMB_MARK;
            tomb_nxt       = tomb_r + CNT_W'(1);
            res_status_nxt = ST_REMOVED;
          end else begin
            res_status_nxt = ST_FOUND;
          end
        end else if (is_empty || at_bound) begin
          // The key is absent. An insert prefers the first tombstone passed,
          // then the empty slot that ended the search.
          res_probes_nxt = n_inc;
          res_slot_nxt   = '0;
          state_nxt      = S_DONE;
          if (act_insert) begin
            if (tomb_any) begin
              ram_we         = 1'b1;
              ram_waddr      = tomb_sel;
              ram_wdata      = key_r;
              tomb_nxt       = tomb_r - CNT_W'(1);
              res_slot_nxt   = tomb_sel;
              res_status_nxt = ST_INSERTED;
            end else if (is_empty) begin
              ram_we         = 1'b1;
              ram_waddr      = pos_r;
              ram_wdata      = key_r;
              used_nxt       = used_r + CNT_W'(1);
              res_slot_nxt   = pos_r;
              res_status_nxt = ST_INSERTED;
            end else begin
              res_status_nxt = ST_FULL;
            end
          end else begin
            res_status_nxt = ST_ABSENT;
          end
        end else begin
          // Keep probing; the next read is issued in this same cycle.
          pos_nxt   = pos_r + n_inc[SLOT_W-1:0];
          ram_re    = 1'b1;
          ram_raddr = pos_r + n_inc[SLOT_W-1:0];
        end
      end

      S_DONE: begin
        // Hand the result to the output register once it is free. The counters
        // already hold their values after this item.
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt            = 1'b1;
          out_item_nxt.status      = res_status_r;
          out_item_nxt.slot_index  = slot_wide[SLOT_IDX_W-1:0];
          out_item_nxt.live_count  = live_wide[COUNT_W-1:0];
          out_item_nxt.probe_count = probes_wide[COUNT_W-1:0];
          state_nxt                = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      pos_r       <= '0;
      n_r         <= '0;
      tomb_seen_r <= 1'b0;
      used_r      <= '0;
      tomb_r      <= '0;
      limit_r     <= LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      n_r         <= n_nxt;
      tomb_seen_r <= tomb_seen_nxt;
      used_r      <= used_nxt;
      tomb_r      <= tomb_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_data;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    tomb_pos_r   <= tomb_pos_nxt;
    action_r     <= action_nxt;
    key_r        <= key_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_probes_r <= res_probes_nxt;
    out_item_r   <= out_item_nxt;
  end

  // A probe run never goes past the table size.
  a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROBE) |-> (n_r < CNT_W'(SLOT_COUNT)))
    else $error("probe count reached the table size while still probing");

  // Tombstones are a subset of used slots, and used slots never exceed the table.
  a_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (tomb_r <= used_r) && (used_r <= CNT_W'(SLOT_COUNT)))
    else $error("occupancy counters out of range");

  // The slot memory is written only by the clearing sweep or at the end of a probe run.
  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> ((state_r == S_CLEAR) || ((state_r == S_PROBE) && (state_nxt == S_DONE))))
    else $error("slot memory written outside the sweep or a probe end");

  // A new result appears only when the sequencer hands one over.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result appeared without a finished item");

endmodule
